// ===== sv/kcs_pkg.sv =====
// Package for the keyframe curve sampler: FSM state type, command and status codes,
// field widths and the packed layout of one keyframe table entry.
// No dependencies.
package kcs_pkg;

    localparam int KEY_COUNT_W = 7;
    localparam int SLOT_W      = 6;
    localparam int TIME_W      = 32;
    localparam int VAL_W       = 32;
    localparam int SEG_W       = 6;
    localparam int STATUS_W    = 3;
    localparam int FRAC_W      = 16;
    localparam int DIV_CNT_W   = 4;
    localparam int PROD_W      = VAL_W + 1 + FRAC_W + 1;
    localparam int IN_DATA_W   = 168;
    localparam int OUT_DATA_W  = 104;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INTERP = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FIRST  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_LAST   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ZERO   = 3'd4;

    localparam logic [1:0] LANE_X    = 2'd0;
    localparam logic [1:0] LANE_Y    = 2'd1;
    localparam logic [1:0] LANE_Z    = 2'd2;
    localparam logic [1:0] LANE_DONE = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0]  z;
        logic [VAL_W-1:0]  y;
        logic [VAL_W-1:0]  x;
        logic [TIME_W-1:0] t;
    } key_entry_t;

    localparam int ENTRY_W = $bits(key_entry_t);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FIRST = 9'b000000010,
        ST_SRCH  = 9'b000000100,
        ST_LAST  = 9'b000001000,
        ST_RDA   = 9'b000010000,
        ST_RDB   = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_MUL   = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

endpackage

// ===== sv/kcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcs_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/keyframe_curve_sampler.sv =====
// Keyframe curve sampler top level: keyframe table in one RAM, binary search,
// bit-serial fraction divider and a shared multiplier for the three components.
// Depends on kcs_pkg and kcs_ram.
//
// Usage:
//   s_* carries one item per beat. s_tuser selects the command: write a keyframe
//   (slot, time, x, y, z) into the table, or sample the curve at query_time.
//   m_* returns one beat per sample: x, y, z, segment index and a status code.
//   cfg_* writes key_count, the number of table entries in use; cfg_ready is
//   always high. Write it only while no sample is in flight.
// Operation:
//   A write is stored on acceptance and the next beat can be taken in the following cycle.
//   A sample reads the first entry, makes one table read per binary search step,
//   reads the two segment ends, runs a 16-bit restoring divide and passes x, y and z
//   through the multiplier in turn; no new beat is taken until its result is loaded.
//   The divide is skipped when the fraction saturates; end cases finish earlier.
// Reset: clears key_count and the control state; table contents stay undefined
//   until written.
// Stall: the result sits in the output register while m_tready is low; the next
//   beat is still taken and worked on, and it waits at its end for the register.
module keyframe_curve_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // key_slot[5:0], key_time[37:6], key_x[69:38], key_y[101:70], key_z[133:102],
    // query_time[165:134], zero fill [167:166]
    input  logic [kcs_pkg::IN_DATA_W-1:0]         s_tdata,
    // command[0]
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], segment_index[101:96], zero fill [103:102]
    output logic [kcs_pkg::OUT_DATA_W-1:0]        m_tdata,
    // sample_status[2:0]
    output logic [kcs_pkg::STATUS_W-1:0]          m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kcs_pkg::KEY_COUNT_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = (AW + 1 > kcs_pkg::KEY_COUNT_W) ? AW + 1 : kcs_pkg::KEY_COUNT_W;
    localparam int VW = kcs_pkg::VAL_W;
    localparam int FW = kcs_pkg::FRAC_W;

    // input fields
    logic [kcs_pkg::SLOT_W-1:0] in_slot;
    logic [kcs_pkg::TIME_W-1:0] in_time;
    logic [VW-1:0]              in_x;
    logic [VW-1:0]              in_y;
    logic [VW-1:0]              in_z;
    logic [kcs_pkg::TIME_W-1:0] in_query;

    assign in_slot  = s_tdata[5:0];
    assign in_time  = s_tdata[37:6];
    assign in_x     = s_tdata[69:38];
    assign in_y     = s_tdata[101:70];
    assign in_z     = s_tdata[133:102];
    assign in_query = s_tdata[165:134];

    // control registers
    kcs_pkg::state_t                 state_reg, state_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [kcs_pkg::KEY_COUNT_W-1:0] key_count_reg, key_count_next;
    logic [kcs_pkg::DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [1:0]                      lane_reg, lane_next;

    // payload registers
    logic [kcs_pkg::TIME_W-1:0]      q_reg, q_next;
    logic [CW-1:0]                   n_reg, n_next;
    logic [CW-1:0]                   first_reg, first_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   mid_reg, mid_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    kcs_pkg::key_entry_t             a_reg, a_next;
    logic signed [VW:0]              diff_x_reg, diff_x_next;
    logic signed [VW:0]              diff_y_reg, diff_y_next;
    logic signed [VW:0]              diff_z_reg, diff_z_next;
    logic [kcs_pkg::TIME_W-1:0]      s_reg, s_next;
    logic [kcs_pkg::TIME_W-1:0]      rem_reg, rem_next;
    logic [FW-1:0]                   quot_reg, quot_next;
    logic signed [kcs_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [VW-1:0]                   res_x_reg, res_x_next;
    logic [VW-1:0]                   res_y_reg, res_y_next;
    logic [VW-1:0]                   res_z_reg, res_z_next;
    logic [AW-1:0]                   res_seg_reg, res_seg_next;
    logic [kcs_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [kcs_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [kcs_pkg::STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    // table RAM
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [AW-1:0]                   ram_raddr;
    kcs_pkg::key_entry_t             ram_wentry;
    logic [kcs_pkg::ENTRY_W-1:0]     ram_rdata;
    kcs_pkg::key_entry_t             rd_entry;

    logic                            s_accept;

    assign s_tready  = (state_reg == kcs_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign rd_entry  = kcs_pkg::key_entry_t'(ram_rdata);

    assign ram_we           = s_accept && (s_tuser == kcs_pkg::CMD_WRITE)
                              && (CW'(in_slot) < CW'(MAX_KEYS));
    assign ram_waddr        = AW'(in_slot);
    assign ram_wentry.t     = in_time;
    assign ram_wentry.x     = in_x;
    assign ram_wentry.y     = in_y;
    assign ram_wentry.z     = in_z;

    kcs_ram #(
        .WIDTH (kcs_pkg::ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [CW-1:0]              half;
        logic [CW-1:0]              first_n;
        logic [CW-1:0]              count_n;
        logic [CW-1:0]              n_clip;
        logic [kcs_pkg::TIME_W-1:0] dq;
        logic [kcs_pkg::TIME_W:0]   rem_sh;
        logic signed [VW:0]         diff_sel;
        logic signed [FW:0]         frac_s;

        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        key_count_next  = key_count_reg;
        div_cnt_next    = div_cnt_reg;
        lane_next       = lane_reg;
        q_next          = q_reg;
        n_next          = n_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        a_next          = a_reg;
        diff_x_next     = diff_x_reg;
        diff_y_next     = diff_y_reg;
        diff_z_next     = diff_z_reg;
        s_next          = s_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        prod_next       = prod_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_z_next      = res_z_reg;
        res_seg_next    = res_seg_reg;
        res_status_next = res_status_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_raddr       = '0;

        half     = count_reg >> 1;
        first_n  = first_reg;
        count_n  = count_reg;
        n_clip   = (CW'(key_count_reg) > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(key_count_reg);
        dq       = '0;
        rem_sh   = {rem_reg, 1'b0};
        diff_sel = diff_z_reg;
        frac_s   = $signed({1'b0, quot_reg});

        if (cfg_valid && cfg_ready)
        begin
            key_count_next = cfg_data;
        end

        // drain output register
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            kcs_pkg::ST_IDLE:
            begin
                if (s_accept && (s_tuser == kcs_pkg::CMD_SAMPLE))
                begin
                    q_next = in_query;
                    n_next = n_clip;
                    if (n_clip == '0)
                    begin
                        res_x_next      = '0;
                        res_y_next      = '0;
                        res_z_next      = '0;
                        res_seg_next    = '0;
                        res_status_next = kcs_pkg::STATUS_EMPTY;
                        state_next      = kcs_pkg::ST_EMIT;
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        state_next = kcs_pkg::ST_FIRST;
                    end
                end
            end
            kcs_pkg::ST_FIRST:
            begin
                if ((n_reg == CW'(1)) || (q_reg <= rd_entry.t))
                begin
                    res_x_next      = rd_entry.x;
                    res_y_next      = rd_entry.y;
                    res_z_next      = rd_entry.z;
                    res_seg_next    = '0;
                    res_status_next = kcs_pkg::STATUS_FIRST;
                    state_next      = kcs_pkg::ST_EMIT;
                end
                else
                begin
                    first_next = '0;
                    count_next = n_reg;
                    mid_next   = n_reg >> 1;
                    ram_raddr  = AW'(n_reg >> 1);
                    state_next = kcs_pkg::ST_SRCH;
                end
            end
            kcs_pkg::ST_SRCH:
            begin
                if (!(q_reg < rd_entry.t))
                begin
                    first_n = mid_reg + CW'(1);
                    count_n = count_reg - half - CW'(1);
                end
                else
                begin
                    count_n = half;
                end
                first_next = first_n;
                count_next = count_n;
                if (count_n != '0)
                begin
                    mid_next  = first_n + (count_n >> 1);
                    ram_raddr = AW'(first_n + (count_n >> 1));
                end
                else if (first_n >= n_reg)
                begin
                    idx_next   = AW'(n_reg - CW'(1));
                    ram_raddr  = AW'(n_reg - CW'(1));
                    state_next = kcs_pkg::ST_LAST;
                end
                else
                begin
                    idx_next   = (first_n == '0) ? '0 : AW'(first_n - CW'(1));
                    ram_raddr  = (first_n == '0) ? '0 : AW'(first_n - CW'(1));
                    state_next = kcs_pkg::ST_RDA;
                end
            end
            kcs_pkg::ST_LAST:
            begin
                res_x_next      = rd_entry.x;
                res_y_next      = rd_entry.y;
                res_z_next      = rd_entry.z;
                res_seg_next    = idx_reg;
                res_status_next = kcs_pkg::STATUS_LAST;
                state_next      = kcs_pkg::ST_EMIT;
            end
            kcs_pkg::ST_RDA:
            begin
                a_next     = rd_entry;
                ram_raddr  = idx_reg + AW'(1);
                state_next = kcs_pkg::ST_RDB;
            end
            kcs_pkg::ST_RDB:
            begin
                res_seg_next = idx_reg;
                if (rd_entry.t <= a_reg.t)
                begin
                    res_x_next      = a_reg.x;
                    res_y_next      = a_reg.y;
                    res_z_next      = a_reg.z;
                    res_status_next = kcs_pkg::STATUS_ZERO;
                    state_next      = kcs_pkg::ST_EMIT;
                end
                else
                begin
                    dq          = (q_reg >= a_reg.t) ? (q_reg - a_reg.t) : '0;
                    s_next      = rd_entry.t - a_reg.t;
                    diff_x_next = $signed({rd_entry.x[VW-1], rd_entry.x})
                                  - $signed({a_reg.x[VW-1], a_reg.x});
                    diff_y_next = $signed({rd_entry.y[VW-1], rd_entry.y})
                                  - $signed({a_reg.y[VW-1], a_reg.y});
                    diff_z_next = $signed({rd_entry.z[VW-1], rd_entry.z})
                                  - $signed({a_reg.z[VW-1], a_reg.z});
                    lane_next   = kcs_pkg::LANE_X;
                    if (dq >= (rd_entry.t - a_reg.t))
                    begin
                        quot_next  = '1;
                        state_next = kcs_pkg::ST_MUL;
                    end
                    else
                    begin
                        rem_next     = dq;
                        quot_next    = '0;
                        div_cnt_next = '1;
                        state_next   = kcs_pkg::ST_DIV;
                    end
                end
            end
            kcs_pkg::ST_DIV:
            begin
                if (rem_sh >= {1'b0, s_reg})
                begin
                    rem_next  = kcs_pkg::TIME_W'(rem_sh - {1'b0, s_reg});
                    quot_next = {quot_reg[FW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[kcs_pkg::TIME_W-1:0];
                    quot_next = {quot_reg[FW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - kcs_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    state_next = kcs_pkg::ST_MUL;
                end
            end
            kcs_pkg::ST_MUL:
            begin
                case (lane_reg)
                    kcs_pkg::LANE_X: diff_sel = diff_x_reg;
                    kcs_pkg::LANE_Y: diff_sel = diff_y_reg;
                    default:         diff_sel = diff_z_reg;
                endcase
                prod_next = diff_sel * frac_s;
                case (lane_reg)
                    kcs_pkg::LANE_Y:    res_x_next = a_reg.x + prod_reg[VW+FW-1:FW];
                    kcs_pkg::LANE_Z:    res_y_next = a_reg.y + prod_reg[VW+FW-1:FW];
                    kcs_pkg::LANE_DONE: res_z_next = a_reg.z + prod_reg[VW+FW-1:FW];
                    default:            res_x_next = res_x_reg;
                endcase
                lane_next = lane_reg + 2'd1;
                if (lane_reg == kcs_pkg::LANE_DONE)
                begin
                    res_status_next = kcs_pkg::STATUS_INTERP;
                    state_next      = kcs_pkg::ST_EMIT;
                end
            end
            kcs_pkg::ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, kcs_pkg::SEG_W'(res_seg_reg),
                                     res_z_reg, res_y_reg, res_x_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = kcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kcs_pkg::ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            key_count_reg <= '0;
            div_cnt_reg   <= '0;
            lane_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            key_count_reg <= key_count_next;
            div_cnt_reg   <= div_cnt_next;
            lane_reg      <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        n_reg          <= n_next;
        first_reg      <= first_next;
        count_reg      <= count_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        a_reg          <= a_next;
        diff_x_reg     <= diff_x_next;
        diff_y_reg     <= diff_y_next;
        diff_z_reg     <= diff_z_next;
        s_reg          <= s_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        prod_reg       <= prod_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_z_reg      <= res_z_next;
        res_seg_reg    <= res_seg_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

`ifndef NO_ASSERTIONS
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == kcs_pkg::ST_IDLE))
        else $error("table write outside idle");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kcs_pkg::ST_SRCH) |-> (mid_reg < n_reg))
        else $error("search probe beyond key count");

    a_segment_end_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kcs_pkg::ST_RDA) |-> (CW'(idx_reg) + CW'(1) < n_reg))
        else $error("segment end beyond key count");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kcs_pkg::ST_DIV) |-> (rem_reg < s_reg))
        else $error("divider remainder not below span");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == kcs_pkg::ST_EMIT) && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid_reg && (state_reg == kcs_pkg::ST_IDLE)))
        else $error("result not loaded into output register");
`endif

endmodule
